// ----- hw/rtl/sobel_edge_magnitude_defines.svh -----
// Assertion macros for the edge detector
`ifndef SOBEL_EDGE_MAGNITUDE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_DEFINES_SVH

`define SEM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("immediate check failed");

`define SEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hw/rtl/sem_pkg.sv -----
package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int WCFG_W     = 12;
  localparam int HCFG_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RST = HCFG_W'(480);

  typedef struct packed {
    logic             pix;
    logic             last;
    logic             has;
    logic             top;
    logic             bot;
    logic             w1;
    logic             c0;
    logic             c1;
    logic [COL_W-1:0] col;
    logic [7:0]       gray;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_UPD,
    B_SQ,
    B_ROOT,
    B_OUT
  } back_state_e;

endpackage

// ----- hw/rtl/sem_ram.sv -----
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/sem_front.sv -----
module sem_front import sem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,  // red, green, blue
  input  logic                  s_axis_tuser_i,  // flush
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  q_stat_t               q_stat_i,
  output logic                  push_o,
  output cmd_t                  cmd_o
);

  logic [WCFG_W-1:0] width_q;
  logic [HCFG_W-1:0] height_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [HCFG_W-1:0] row_q, row_d;
  logic [EW_W-1:0]   drain_q, drain_d;
  logic [EW_W-1:0]   w_eff;
  logic [HCFG_W-1:0] h_eff;
  logic [COL_W-1:0]  col_c;
  logic [EW_W-1:0]   col_inc;
  logic              pphase, last, flush, item_ok, acc;
  logic [25:0]       gray_sum;

  assign flush           = s_axis_tuser_i;
  assign s_axis_tready_o = !q_stat_i.full;
  assign cfg_ready_o     = 1'b1;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    if (width_q == '0) begin
      w_eff = EW_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = EW_W'(width_q);
    end
    h_eff    = (height_q == '0) ? HCFG_W'(1) : height_q;
    pphase   = row_q < h_eff;
    col_c    = (EW_W'(col_q) >= w_eff) ? '0 : col_q;
    col_inc  = EW_W'(col_c) + EW_W'(1);
    last     = drain_q >= w_eff;
    item_ok  = pphase ? !flush : flush;
    gray_sum = 26'(26'(19595) * 26'(s_axis_tdata_i[7:0]))
             + 26'(26'(38470) * 26'(s_axis_tdata_i[15:8]))
             + 26'(26'(7471) * 26'(s_axis_tdata_i[23:16]));

    cmd_o.gray = gray_sum[23:16];
    cmd_o.w1   = w_eff == EW_W'(1);
    cmd_o.pix  = pphase;
    if (pphase) begin
      cmd_o.last = 1'b0;
      cmd_o.col  = col_c;
      cmd_o.c0   = col_c == '0;
      cmd_o.c1   = col_c == COL_W'(1);
      cmd_o.has  = (row_q >= HCFG_W'(2)) || (row_q == HCFG_W'(1) && col_c != '0);
      cmd_o.top  = row_q <= HCFG_W'(1);
      cmd_o.bot  = 1'b0;
    end else begin
      cmd_o.last = last;
      cmd_o.col  = last ? '0 : drain_q[COL_W-1:0];
      cmd_o.c0   = last || drain_q == '0;
      cmd_o.c1   = !last && drain_q == EW_W'(1);
      cmd_o.has  = last || h_eff >= HCFG_W'(2) || drain_q != '0;
      cmd_o.top  = !last && h_eff == HCFG_W'(1);
      cmd_o.bot  = 1'b1;
    end

    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (pphase) begin
      if (col_inc >= w_eff) begin
        col_d   = '0;
        row_d   = row_q + HCFG_W'(1);
        drain_d = '0;
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end else if (last) begin
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
    end else begin
      drain_d = drain_q + EW_W'(1);
    end
  end

  assign push_o = acc && item_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
      drain_q  <= '0;
    end else if (cfg_valid_i && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT)) begin
      if (cfg_index_i == REG_WIDTH) begin
        width_q <= cfg_data_i[WCFG_W-1:0];
      end else begin
        height_q <= cfg_data_i;
      end
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else if (push_o) begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

endmodule

// ----- hw/rtl/sem_queue.sv -----
module sem_queue import sem_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    cmd_i,
  input  logic    pop_i,
  output cmd_t    cmd_o,
  output q_stat_t stat_o
);

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign cmd_o        = ent_q[rp_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ----- hw/rtl/sem_back.sv -----
module sem_back import sem_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_stat_t     q_stat_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        busy_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // edge_magnitude
  output logic        m_axis_tlast_o
);

  function automatic logic signed [11:0] ext(input logic [7:0] v);
    ext = signed'({4'd0, v});
  endfunction

  back_state_e      state_q, state_d;
  cmd_t             cmd_q;
  logic [7:0]       win_q [3][3];
  logic [7:0]       newer_rd, older_rd;
  logic [7:0]       ncol [3];
  logic [7:0]       lc [3], mc [3], rc [3];
  logic signed [11:0] sx_q, sy_q, sx_d, sy_d;
  logic signed [23:0] sum;
  logic [21:0]      s_q;
  logic [7:0]       m_q, t;
  logic [15:0]      tsq;
  logic [2:0]       k_q;
  logic             load_out, upd;

  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_newer (
    .clk_i  (clk_i),
    .we_i   (upd && cmd_q.pix),
    .waddr_i(cmd_q.col),
    .wdata_i(cmd_q.gray),
    .raddr_i(cmd_i.col),
    .rdata_o(newer_rd)
  );

  sem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_older (
    .clk_i  (clk_i),
    .we_i   (upd && cmd_q.pix),
    .waddr_i(cmd_q.col),
    .wdata_i(newer_rd),
    .raddr_i(cmd_i.col),
    .rdata_o(older_rd)
  );

  always_comb begin
    ncol[0] = cmd_q.top ? newer_rd : older_rd;
    ncol[1] = newer_rd;
    ncol[2] = cmd_q.bot ? newer_rd : cmd_q.gray;
    for (int i = 0; i < 3; i++) begin
      mc[i] = win_q[2][i];
      if (cmd_q.c0) begin
        lc[i] = cmd_q.w1 ? win_q[2][i] : win_q[1][i];
        rc[i] = win_q[2][i];
      end else begin
        lc[i] = cmd_q.c1 ? win_q[2][i] : win_q[1][i];
        rc[i] = ncol[i];
      end
    end
    sx_d = (ext(rc[0]) - ext(lc[0])) + 12'sd2 * (ext(rc[1]) - ext(lc[1]))
         + (ext(rc[2]) - ext(lc[2]));
    sy_d = (ext(lc[2]) + 12'sd2 * ext(mc[2]) + ext(rc[2]))
         - (ext(lc[0]) + 12'sd2 * ext(mc[0]) + ext(rc[0]));
    sum  = sx_q * sx_q + sy_q * sy_q;
    t    = m_q | (8'd1 << k_q);
    tsq  = 16'(t) * 16'(t);
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    upd      = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = B_UPD;
        end
      end
      B_UPD: begin
        upd     = 1'b1;
        state_d = cmd_q.has ? B_SQ : B_IDLE;
      end
      B_SQ: state_d = B_ROOT;
      B_ROOT: begin
        if (k_q == '0) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!m_axis_tvalid_o || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign busy_o = state_q != B_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= B_IDLE;
      m_axis_tvalid_o <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_q[c][r] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        m_axis_tvalid_o <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_axis_tvalid_o <= 1'b0;
      end
      if (upd && !cmd_q.last) begin
        for (int r = 0; r < 3; r++) begin
          win_q[0][r] <= win_q[1][r];
          win_q[1][r] <= win_q[2][r];
          win_q[2][r] <= ncol[r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (upd) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
    end
    if (state_q == B_SQ) begin
      s_q <= sum[21:0];
      m_q <= '0;
      k_q <= 3'd7;
    end
    if (state_q == B_ROOT) begin
      if ({6'd0, tsq} <= s_q) begin
        m_q <= t;
      end
      k_q <= k_q - 3'd1;
    end
    if (load_out) begin
      m_axis_tdata_o <= m_q;
      m_axis_tlast_o <= cmd_q.last;
    end
  end

endmodule

// ----- hw/rtl/sobel_edge_magnitude.sv -----
// The back end takes one queued item at a time: update, then for a result square, root and
// output, where it waits on the receiver. The two-entry queue lets the front take items
// in the meantime until it is full; the root is an eight-step bit-serial square root.
// Reset: rst_ni clears the counters, window, queue and output; width 640, height 480.
// Line stores are not cleared; no result depends on an unwritten entry.
module sobel_edge_magnitude import sem_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [23:0]           s_axis_tdata_i,  // red, green, blue
  input  logic                  s_axis_tuser_i,  // flush
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,  // edge_magnitude
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

`include "sobel_edge_magnitude_defines.svh"

  q_stat_t q_stat;
  cmd_t    push_cmd, head_cmd;
  logic    push, pop, busy;

  sem_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_stat_i       (q_stat),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  sem_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (push_cmd),
    .pop_i (pop),
    .cmd_o (head_cmd),
    .stat_o(q_stat)
  );

  sem_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .busy_o         (busy),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  `SEM_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
  `SEM_ASSERT_NOW(a_pop_only_idle, pop, !q_stat.empty && !busy)
  `SEM_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty)

endmodule

// ----- test/testbench.sv -----
module testbench;
  import sem_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1950;

  typedef struct {
    logic [7:0] mag;
    logic       last;
  } edge_result_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          val;
    bit                   flush;
    logic [23:0]          rgb;
    bit                   typed;
    logic [7:0]           mag;
    logic                 last;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [23:0]           s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [7:0]            m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sobel_edge_magnitude i_dut (.*);

  always #6 clk_i = ~clk_i;

  edge_result_t edge_expected[$];
  int unsigned  cycles = 0;
  int unsigned  stall_left = 0;
  int           mismatches = 0;
  int           items_taken = 0;

  logic [7:0]  gray_win[9];
  logic [7:0]  older_row[MAX_WIDTH];
  logic [7:0]  newer_row[MAX_WIDTH];
  int unsigned col_pos, row_pos, drain_pos, width_reg, height_reg;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic logic [7:0] sobel_mag(input int l, input int m, input int r);
    int          sx, sy;
    int unsigned s, root, t;
    sx = (int'(gray_win[r]) - int'(gray_win[l]))
       + 2 * (int'(gray_win[r+1]) - int'(gray_win[l+1]))
       + (int'(gray_win[r+2]) - int'(gray_win[l+2]));
    sy = (int'(gray_win[l+2]) + 2 * int'(gray_win[m+2]) + int'(gray_win[r+2]))
       - (int'(gray_win[l]) + 2 * int'(gray_win[m]) + int'(gray_win[r]));
    s = sx * sx + sy * sy;
    root = 0;
    for (int b = 128; b != 0; b = b >> 1) begin
      t = root | b;
      if (t * t <= s) root = t;
    end
    return root[7:0];
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [15:0] val);
    if (idx == REG_WIDTH) width_reg = val[11:0];
    else if (idx == REG_HEIGHT) height_reg = val;
    else return;
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
  endfunction

  function automatic void predict_edge(input bit fl, input logic [23:0] rgb,
                                       output bit taken, output bit has,
                                       output edge_result_t res);
    int unsigned w, h, r, c, gray;
    bit          pix, last;
    logic [7:0]  n, o;
    w = eff_width();
    h = eff_height();
    pix = row_pos < h;
    last = 0;
    gray = 0;
    taken = 0;
    has = 0;
    res = '{mag: '0, last: 1'b0};
    if (pix) begin
      if (fl) return;
      if (col_pos >= w) col_pos = 0;
      r = row_pos;
      c = col_pos;
      gray = (19595 * rgb[7:0] + 38470 * rgb[15:8] + 7471 * rgb[23:16]) >> 16;
    end else begin
      if (!fl) return;
      if (drain_pos >= w) begin
        last = 1;
        r = h + 1;
        c = 0;
      end else begin
        r = h;
        c = drain_pos;
      end
    end
    taken = 1;
    has = (r >= 2) || (r == 1 && c >= 1);
    if (c == 0 && has) res.mag = sobel_mag((w == 1) ? 6 : 3, 6, 6);
    if (!last) begin
      n = newer_row[c];
      o = older_row[c];
      for (int i = 0; i < 6; i++) gray_win[i] = gray_win[i+3];
      gray_win[6] = (r <= 1) ? n : o;
      gray_win[7] = n;
      gray_win[8] = (r >= h) ? n : gray[7:0];
      if (pix) begin
        older_row[c] = n;
        newer_row[c] = gray[7:0];
      end
    end
    if (c >= 1 && has) res.mag = sobel_mag((c == 1) ? 3 : 0, 3, 6);
    if (pix) begin
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 16'hFFFF;
        drain_pos = 0;
      end
    end else if (last) begin
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
    end else begin
      drain_pos = (drain_pos + 1) & 12'hFFF;
    end
    res.last = last;
  endfunction

  function automatic bit quiet_stretch();
    return cycles >= 6000 && cycles < 14000;
  endfunction

  task automatic send_word(input bit fl, input logic [23:0] rgb, input bit typed,
                           input edge_result_t typed_res);
    bit           ready_seen, taken, has;
    edge_result_t res;
    while (!quiet_stretch() && $urandom_range(0, 99) < 11) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= fl;
    s_axis_tdata_i  <= rgb;
    do begin
      @(negedge clk_i);
      ready_seen = s_axis_tready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    predict_edge(fl, rgb, taken, has, res);
    if (taken) items_taken++;
    if (has) edge_expected.push_back(typed ? typed_res : res);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    bit ready_seen;
    s_axis_tvalid_i <= 1'b0;
    while (edge_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do begin
      @(negedge clk_i);
      ready_seen = cfg_ready_o;
      @(posedge clk_i);
    end while (!ready_seen);
    apply_register(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_pixel();
    edge_result_t none;
    none = '{mag: '0, last: 1'b0};
    send_word(1'b0, 24'($urandom()), 1'b0, none);
  endtask

  task automatic run_frame(input logic [15:0] wv, input logic [15:0] hv, input int cut);
    int unsigned w, h, sent;
    edge_result_t none;
    none = '{mag: '0, last: 1'b0};
    if ($urandom_range(0, 1)) begin
      write_register(REG_WIDTH, wv);
      write_register(REG_HEIGHT, hv);
    end else begin
      write_register(REG_HEIGHT, hv);
      write_register(REG_WIDTH, wv);
    end
    if ($urandom_range(0, 19) == 0)
      write_register(CFG_IDX_W'($urandom_range(2, 3)), 16'($urandom()));
    w = eff_width();
    h = eff_height();
    sent = 0;
    for (int unsigned i = 0; i < w * h; i++) begin
      if (cut >= 0 && sent >= cut) return;
      if ($urandom_range(0, 99) < 4) send_word(1'b1, 24'($urandom()), 1'b0, none);
      send_pixel();
      sent++;
    end
    for (int unsigned i = 0; i <= w; i++) begin
      if (cut >= 0 && sent >= cut) return;
      if ($urandom_range(0, 99) < 4) send_pixel();
      send_word(1'b1, 24'($urandom()), 1'b0, none);
      sent++;
    end
  endtask

  stim_row_t directed[22] = '{
    '{1, REG_WIDTH,  16'd1, 0, 24'h0,      0, 8'd0, 1'b0},
    '{1, REG_HEIGHT, 16'd1, 0, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'hFFFFFF, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'h000000, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      1, 8'd0, 1'b1},
    '{1, REG_WIDTH,  16'd3, 0, 24'h0,      0, 8'd0, 1'b0},
    '{1, REG_HEIGHT, 16'd3, 0, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'hFFFFFF, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'h000000, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'hFFFFFF, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'h0000FF, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'h00FF00, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'hFF0000, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'hFFFFFF, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'h000000, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 0, 24'hFFFFFF, 0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      0, 8'd0, 1'b0},
    '{0, REG_WIDTH,  16'd0, 1, 24'h0,      0, 8'd0, 1'b0}
  };

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL sobel_edge_magnitude");
      $finish;
    end
  end

  // hold off the receiver once for a long stretch so the block backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (cycles == 3000) begin
      stall_left <= 600;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= quiet_stretch() || ($urandom_range(0, 99) >= 11);
    end
  end

  initial begin
    bit           fire;
    logic [7:0]   got_mag;
    logic         got_last;
    edge_result_t want;
    forever begin
      @(negedge clk_i);
      fire = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
      got_mag = m_axis_tdata_o;
      got_last = m_axis_tlast_o;
      @(posedge clk_i);
      if (fire) begin
        if (edge_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: mag %0d last %0d", got_mag, got_last);
        end else begin
          want = edge_expected.pop_front();
          if (got_mag !== want.mag || got_last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: mag exp %0d got %0d, last exp %0d got %0d",
                       want.mag, got_mag, want.last, got_last);
          end
        end
      end
    end
  end

  initial begin
    edge_result_t typed_res;
    int           frame_no;
    int           wr, hr, cut;
    width_reg = WIDTH_RST;
    height_reg = HEIGHT_RST;
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
    foreach (gray_win[i]) gray_win[i] = '0;
    foreach (older_row[i]) older_row[i] = '0;
    foreach (newer_row[i]) newer_row[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_register(directed[i].idx, directed[i].val);
      end else begin
        typed_res = '{mag: directed[i].mag, last: directed[i].last};
        send_word(directed[i].flush, directed[i].rgb, directed[i].typed, typed_res);
      end
    end

    items_taken = 0;
    frame_no = 0;
    while (items_taken < RANDOM_ITEMS) begin
      cut = -1;
      case (frame_no)
        4: begin wr = 4095; hr = 1; cut = 300; end
        7: begin wr = 0; hr = 0; end
        10: begin wr = 1; hr = 65535; cut = 40; end
        13: begin wr = 2048; hr = 2; cut = 300; end
        default: begin
          wr = $urandom_range(1, 12);
          hr = $urandom_range(0, 6);
          if ($urandom_range(0, 9) == 0) wr = $urandom_range(13, 40);
          if ($urandom_range(0, 19) == 0) cut = $urandom_range(0, 30);
        end
      endcase
      run_frame(16'(wr), 16'(hr), cut);
      frame_no++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (edge_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS sobel_edge_magnitude");
    end else begin
      $display("FAIL sobel_edge_magnitude");
    end
    $finish;
  end

endmodule

// ----- sobel_edge_magnitude.f -----
+incdir+hw/rtl
hw/rtl/sem_pkg.sv
hw/rtl/sem_ram.sv
hw/rtl/sem_front.sv
hw/rtl/sem_queue.sv
hw/rtl/sem_back.sv
hw/rtl/sobel_edge_magnitude.sv
test/testbench.sv
